// ===== design/prs80_pkg.sv =====
// Shared constants, types and round functions for the PRESENT-80 encryption pipeline.
`timescale 1ns / 1ps
`default_nettype none
package prs80_pkg;

    localparam int NUM_ROUNDS  = 31;
    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 80;
    localparam int KEY_LOW_W   = KEY_W - BLOCK_W;
    localparam int RC_W        = 5;
    localparam int CFG_INDEX_W = 2;
    // Pipeline depth: the round stages plus the output register
    localparam int LATENCY     = NUM_ROUNDS + 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOWER = 2'd1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [RC_W-1:0]    round_cnt_t;

    // 4-bit S-box
    function automatic logic [3:0] sbox4(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // Apply the S-box to all sixteen nibbles
    function automatic block_t s_layer(input block_t x);
        block_t y;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            y[4*n +: 4] = sbox4(x[4*n +: 4]);
        end
        return y;
    endfunction

    // Bit permutation: bit i moves to 16*i mod 63, bit 63 stays.
    // Destination is the index with its two low bits moved to the top.
    function automatic block_t p_layer(input block_t x);
        block_t     y;
        logic [5:0] src;
        for (int i = 0; i < BLOCK_W; i++) begin
            src = 6'(i);
            y[{src[1:0], src[5:2]}] = x[i];
        end
        return y;
    endfunction

    // One step of the key schedule: rotate left 61, S-box top nibble, add counter
    function automatic key_t key_update(input key_t k, input round_cnt_t rc);
        key_t r;
        r = {k[18:0], k[KEY_W-1:19]};
        r[KEY_W-1 -: 4] = sbox4(r[KEY_W-1 -: 4]);
        r[19:15] = r[19:15] ^ rc;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/present80_block_encrypt.sv =====
// Top level of the pipelined PRESENT-80 block encryptor.
//
// Usage:
//   Input: pulse start with a 64-bit plaintext; a transaction is taken at any
//   rising edge where start is high and busy is low. busy stays low, so a new
//   block can be taken every cycle.
//   Key: write key_upper (index 0) and key_lower (index 1) through the cfg_*
//   channel while no block is in flight; cfg_ready is always high and other
//   indexes are ignored.
//   Output: done is high for exactly one cycle with the ciphertext, once the
//   block has passed the 31 round stages and the output register.
//   Throughput is one block per cycle; each round stage registers the state and
//   the 80-bit key register, so the round keys ride along with the data.
//   The receiver cannot stall; results are presented once and must be taken.
//   Reset clears both key registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module present80_block_encrypt
    import prs80_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [BLOCK_W-1:0]     plaintext,
    output logic                        done,
    output logic [BLOCK_W-1:0]          ciphertext,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BLOCK_W-1:0]     cfg_data
);

    logic [BLOCK_W-1:0]   key_upper_reg;
    logic [BLOCK_W-1:0]   key_upper_next;
    logic [KEY_LOW_W-1:0] key_lower_reg;
    logic [KEY_LOW_W-1:0] key_lower_next;
    logic                 done_reg;
    block_t               ciphertext_reg;
    block_t               ciphertext_next;

    logic   stage_valid [0:NUM_ROUNDS];
    block_t stage_state [0:NUM_ROUNDS];
    key_t   stage_key   [0:NUM_ROUNDS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Decode key register writes
    always_comb
    begin
        key_upper_next = key_upper_reg;
        key_lower_next = key_lower_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_UPPER: key_upper_next = cfg_data;
                REG_KEY_LOWER: key_lower_next = cfg_data[KEY_LOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end
        else
        begin
            key_upper_reg <= key_upper_next;
            key_lower_reg <= key_lower_next;
        end
    end

    // Feed the pipeline with the accepted block and the current key
    assign stage_valid[0] = start && !busy;
    assign stage_state[0] = plaintext;
    assign stage_key[0]   = {key_upper_reg, key_lower_reg};

    // One stage per round
    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        prs80_round_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[r]),
            .in_state  (stage_state[r]),
            .in_key    (stage_key[r]),
            .rc        (RC_W'(r + 1)),
            .out_valid (stage_valid[r+1]),
            .out_state (stage_state[r+1]),
            .out_key   (stage_key[r+1])
        );
    end

    // Final key add into the output register
    assign ciphertext_next = stage_state[NUM_ROUNDS]
                           ^ stage_key[NUM_ROUNDS][KEY_W-1 -: BLOCK_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[NUM_ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid[NUM_ROUNDS])
        begin
            ciphertext_reg <= ciphertext_next;
        end
    end

    assign done       = done_reg;
    assign ciphertext = ciphertext_reg;

`ifndef SYNTHESIS
    // Every accepted block comes out after the full pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted block did not complete on time");

    // A result appears only when the last round stage held a live block
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(stage_valid[NUM_ROUNDS]))
        else $error("result strobe without a block in the last stage");

    // The first round stage is live exactly after an accepted block
    a_stage_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> stage_valid[1])
        else $error("accepted block did not enter the first round stage");
`endif

endmodule
`default_nettype wire

// ===== design/prs80_round_stage.sv =====
// One registered PRESENT-80 round with its key schedule step.
`timescale 1ns / 1ps
`default_nettype none
module prs80_round_stage
    import prs80_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire block_t     in_state,
    input  wire key_t       in_key,
    input  wire round_cnt_t rc,
    output logic            out_valid,
    output block_t          out_state,
    output key_t            out_key
);

    logic   valid_reg;
    block_t state_reg;
    block_t state_next;
    key_t   key_reg;
    key_t   key_next;

    // Add round key, substitute, permute; advance the key register
    always_comb
    begin
        state_next = p_layer(s_layer(in_state ^ in_key[KEY_W-1 -: BLOCK_W]));
        key_next   = key_update(in_key, rc);
    end

    // Carry the valid bit down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload only for a live transaction
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the pipelined PRESENT-80 block encryptor.
`timescale 1ns / 1ps
module tb_top;
    import prs80_pkg::*;

    // Spare register indexes: the block must ignore writes to them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    // S-box entry n sits at bits 4n+3..4n
    localparam logic [63:0] SBOX_TABLE  = 64'h2174_8FE3_DA09_B65C;
    localparam int          ROUND_KEYS  = 32;
    localparam int          CYCLE_LIMIT = 200_000;
    localparam int          SHOWN_LIMIT = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [BLOCK_W-1:0]     plaintext;
    logic                   done;
    logic [BLOCK_W-1:0]     ciphertext;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BLOCK_W-1:0]     cfg_data;

    // Predictor state
    key_t   cipher_key;
    block_t round_keys [0:ROUND_KEYS-1];

    block_t plaintext_backlog [$];
    block_t ciphertext_due [$];

    int  blocks_queued;
    int  blocks_taken;
    int  blocks_checked;
    int  mismatch_cnt;
    int  cycle_cnt;
    int  gap_left;
    int  max_gap;
    bit  took_item;

    present80_block_encrypt dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .plaintext  (plaintext),
        .done       (done),
        .ciphertext (ciphertext),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [3:0] sbox_lookup(input logic [3:0] x);
        return SBOX_TABLE[4*x +: 4];
    endfunction

    // Rebuild all round keys from the 80-bit cipher key
    function automatic void expand_round_keys();
        key_t k;
        k = cipher_key;
        for (int r = 0; r < ROUND_KEYS; r++)
        begin
            round_keys[r] = k[KEY_W-1 -: BLOCK_W];
            k = {k[18:0], k[KEY_W-1:19]};
            k[KEY_W-1 -: 4] = sbox_lookup(k[KEY_W-1 -: 4]);
            k[19:15] = k[19:15] ^ 5'(r + 1);
        end
    endfunction

    // Encrypt one block with the current round keys
    function automatic block_t present_encrypt(input block_t pt);
        block_t s;
        block_t t;
        s = pt;
        for (int r = 0; r < NUM_ROUNDS; r++)
        begin
            s = s ^ round_keys[r];
            for (int n = 0; n < BLOCK_W / 4; n++)
            begin
                t[4*n +: 4] = sbox_lookup(s[4*n +: 4]);
            end
            s[BLOCK_W-1] = t[BLOCK_W-1];
            for (int i = 0; i < BLOCK_W - 1; i++)
            begin
                s[(16 * i) % 63] = t[i];
            end
        end
        return s ^ round_keys[NUM_ROUNDS];
    endfunction

    function automatic void note_failure(input block_t want, input block_t got, input bit orphan);
        mismatch_cnt++;
        if (mismatch_cnt <= SHOWN_LIMIT)
        begin
            if (orphan)
                $display("unexpected ciphertext %h at cycle %0d", got, cycle_cnt);
            else
                $display("ciphertext mismatch at cycle %0d: expected %h got %h",
                         cycle_cnt, want, got);
        end
    endfunction

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Driver: hold start until the transaction is taken, then idle or load the next block
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || took_item)
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (plaintext_backlog.size() != 0)
            begin
                start     <= 1'b1;
                plaintext <= plaintext_backlog.pop_front();
                gap_left = $urandom_range(0, max_gap);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: track key writes, predict taken blocks, check results
    always @(posedge clk)
    begin
        took_item = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY_UPPER: cipher_key[KEY_W-1 -: BLOCK_W] = cfg_data;
                    REG_KEY_LOWER: cipher_key[KEY_LOW_W-1:0] = cfg_data[KEY_LOW_W-1:0];
                    default: ;
                endcase
                expand_round_keys();
            end
            if (start && !busy)
            begin
                took_item = 1'b1;
                ciphertext_due.push_back(present_encrypt(plaintext));
                blocks_taken++;
            end
            if (done)
            begin
                if (ciphertext_due.size() == 0)
                    note_failure('0, ciphertext, 1'b1);
                else
                begin
                    block_t want;
                    want = ciphertext_due.pop_front();
                    if (ciphertext !== want)
                        note_failure(want, ciphertext, 1'b0);
                    blocks_checked++;
                end
            end
        end
    end

    task automatic queue_block(input block_t pt);
        plaintext_backlog.push_back(pt);
        blocks_queued++;
    endtask

    // Block until every queued block is taken and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (blocks_taken != blocks_queued || blocks_checked != blocks_taken);
    endtask

    task automatic write_key_reg(input logic [CFG_INDEX_W-1:0] idx, input block_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic end_key_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Edge patterns run under each directed key
    task automatic queue_edge_blocks();
        queue_block('0);
        queue_block('1);
        queue_block(64'h8000_0000_0000_0000);
        queue_block(64'h0000_0000_0000_0001);
        queue_block(64'hAAAA_AAAA_AAAA_AAAA);
        queue_block(64'h5555_5555_5555_5555);
        queue_block(64'h0123_4567_89AB_CDEF);
    endtask

    function automatic block_t random_block();
        block_t b;
        case ($urandom_range(0, 9))
            0: b = block_t'(1) << $urandom_range(0, BLOCK_W - 1);
            1: b = ~(block_t'(1) << $urandom_range(0, BLOCK_W - 1));
            default: b = {$urandom, $urandom};
        endcase
        return b;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        plaintext    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_KEY_UPPER;
        cfg_data     = '0;
        took_item    = 1'b0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        gap_left     = 0;
        max_gap      = 0;
        cipher_key   = '0;
        expand_round_keys();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset key, back-to-back blocks
        queue_edge_blocks();
        wait_drained();

        // All-ones key; upper data bits of the low register must be dropped
        max_gap = 5;
        write_key_reg(REG_KEY_UPPER, '1);
        write_key_reg(REG_KEY_LOWER, '1);
        end_key_writes();
        queue_edge_blocks();
        wait_drained();

        // Spare indexes are ignored; key with only its MSB and LSB set, junk above the low field
        write_key_reg(REG_SPARE_2, {$urandom, $urandom});
        write_key_reg(REG_KEY_UPPER, 64'h8000_0000_0000_0000);
        write_key_reg(REG_SPARE_3, {$urandom, $urandom});
        write_key_reg(REG_KEY_LOWER, 64'hFFFF_FFFF_FFFF_0000 | 64'(16'h0001));
        end_key_writes();
        queue_block('0);
        queue_block('1);
        queue_block({$urandom, $urandom});
        queue_block({$urandom, $urandom});
        wait_drained();

        // Random phases over a range of keys and pacing
        for (int phase = 0; phase < 8; phase++)
        begin
            max_gap = (phase % 3 == 0) ? 0 : 5;
            case (phase)
                0:
                begin
                    write_key_reg(REG_KEY_UPPER, '0);
                    write_key_reg(REG_KEY_LOWER, 64'(16'hFFFF));
                end
                1:
                begin
                    write_key_reg(REG_KEY_UPPER, '1);
                    write_key_reg(REG_KEY_LOWER, '0);
                end
                2:
                begin
                    write_key_reg(REG_KEY_LOWER, {$urandom, $urandom});
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        write_key_reg(REG_SPARE_2, {$urandom, $urandom});
                    write_key_reg(REG_KEY_UPPER, {$urandom, $urandom});
                    if ($urandom_range(0, 1))
                        write_key_reg(REG_SPARE_3, {$urandom, $urandom});
                    write_key_reg(REG_KEY_LOWER, {$urandom, $urandom});
                end
            endcase
            end_key_writes();
            for (int n = 0; n < 60; n++)
            begin
                queue_block(random_block());
                // Pause mid-phase until the pipeline empties
                if (phase == 4 && n == 29)
                    wait_drained();
            end
            wait_drained();
        end

        // Let the pipeline run dry and catch any stray result
        repeat (LATENCY + 8) @(negedge clk);
        if (ciphertext_due.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
design/prs80_pkg.sv
design/prs80_round_stage.sv
design/present80_block_encrypt.sv
test/tb_top.sv
